/* sv/arhp_pkg.sv */
// Shared types, codes and helpers for the asynchronous request header packer.
`default_nettype none

package arhp_pkg;

  // Request kinds as they arrive on the request channel
  typedef enum logic [2:0] {
    RT_READ_QUAD  = 3'd0,
    RT_READ_BLOCK = 3'd1,
    RT_WRITE_QUAD = 3'd2,
    RT_WRITE_BLK  = 3'd3,
    RT_LOCK       = 3'd4,
    RT_PHY        = 3'd5
  } req_type_e;

  // Completion status carried with each header word
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_ADDR_HIGH = 3'd2,
    ST_UNALIGNED = 3'd3,
    ST_NO_NODE   = 3'd4
  } status_e;

  // Transaction codes of the bus protocol
  localparam logic [3:0] TC_WRITE_QUAD  = 4'h0;
  localparam logic [3:0] TC_WRITE_BLOCK = 4'h1;
  localparam logic [3:0] TC_READ_QUAD   = 4'h4;
  localparam logic [3:0] TC_READ_BLOCK  = 4'h5;
  localparam logic [3:0] TC_LOCK        = 4'h9;

  localparam logic [1:0]  RETRY_CODE   = 2'b01;
  localparam logic [31:0] PHY_QUADLET0 = 32'h0000_00E0;
  localparam int unsigned MAX_WORDS    = 4;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_LOCAL_NODE_ID = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_SPEED = 2'd1;
  localparam logic [1:0] CFG_SWAP_PAYLOAD  = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  dest_node;
    logic [31:0] addr_high;
    logic [31:0] addr_low;
    logic [31:0] data_length;
    logic [5:0]  tlabel;
    logic [2:0]  speed_code;
    logic        use_default_speed;
    logic [15:0] ext_tcode;
    logic [31:0] payload;
    logic [31:0] phy_word1;
    logic [31:0] phy_word2;
  } req_t;

  typedef struct packed {
    logic [15:0] local_node_id;
    logic [2:0]  default_speed;
    logic        swap_payload;
  } cfg_t;

  // One built packet: its words, the index of the last one, its status
  typedef struct packed {
    logic                           emit;
    logic [MAX_WORDS-1:0][31:0]     words;
    logic [$clog2(MAX_WORDS)-1:0]   last_idx;
    status_e                        status;
  } pkt_t;

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

`default_nettype wire

/* sv/arhp_if.sv */
// Valid/ready channel interfaces for requests and header words.
`default_nettype none

interface arhp_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [5:0]  dest_node;
  logic [31:0] addr_high;
  logic [31:0] addr_low;
  logic [31:0] data_length;
  logic [5:0]  tlabel;
  logic [2:0]  speed_code;
  logic        use_default_speed;
  logic [15:0] ext_tcode;
  logic [31:0] payload;
  logic [31:0] phy_word1;
  logic [31:0] phy_word2;

  modport source (
    output valid, req_type, dest_node, addr_high, addr_low, data_length, tlabel,
           speed_code, use_default_speed, ext_tcode, payload, phy_word1, phy_word2,
    input  ready
  );
  modport sink (
    input  valid, req_type, dest_node, addr_high, addr_low, data_length, tlabel,
           speed_code, use_default_speed, ext_tcode, payload, phy_word1, phy_word2,
    output ready
  );
endinterface

interface arhp_hdr_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;
  logic        is_last;
  logic [2:0]  status;

  modport source (output valid, header_word, is_last, status, input ready);
  modport sink (input valid, header_word, is_last, status, output ready);
endinterface

`default_nettype wire

/* sv/async_request_header_packer_unit.sv */
// Top level of the asynchronous request header packer.
//
//   channel   dir  handshake            payload
//   req_i     in   valid/ready          one request (type, addresses, length, ...)
//   hdr_o     out  valid/ready          header_word, is_last, status
//   cfg_*     in   cfg_we_i, no wait    cfg_idx_i, cfg_data_i
//
// A request is registered on accept, built in the next cycle and loaded into
// the result buffer, which sends one word per cycle while the output is ready:
// 3 or 4 words per request (1 on a rejected request, 0 on an unknown type).
// The next request is taken while the current one drains. Reset clears the
// configuration registers and all valid flags.
// Output stalls hold the current word and back up into the request register.
`default_nettype none

module async_request_header_packer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  arhp_req_if.sink    req_i,
  arhp_hdr_if.source  hdr_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import arhp_pkg::*;

  cfg_t cfg_q;
  req_t req_q;
  req_t req_in;
  logic s1_valid_q;
  logic s1_take;
  logic emit_ready;
  pkt_t pkt;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOCAL_NODE_ID: cfg_q.local_node_id <= cfg_data_i;
        CFG_DEFAULT_SPEED: cfg_q.default_speed <= cfg_data_i[2:0];
        CFG_SWAP_PAYLOAD:  cfg_q.swap_payload  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Gather the request word
  assign req_in = '{
    req_type:          req_i.req_type,
    dest_node:         req_i.dest_node,
    addr_high:         req_i.addr_high,
    addr_low:          req_i.addr_low,
    data_length:       req_i.data_length,
    tlabel:            req_i.tlabel,
    speed_code:        req_i.speed_code,
    use_default_speed: req_i.use_default_speed,
    ext_tcode:         req_i.ext_tcode,
    payload:           req_i.payload,
    phy_word1:         req_i.phy_word1,
    phy_word2:         req_i.phy_word2
  };

  // Drop unknown types, otherwise hand off when the buffer takes the packet
  assign s1_take     = s1_valid_q && (!pkt.emit || emit_ready);
  assign req_i.ready = !s1_valid_q || s1_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q <= req_in;
    end
  end

  arhp_build u_build (
    .req_i (req_q),
    .cfg_i (cfg_q),
    .pkt_o (pkt)
  );

  arhp_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s1_valid_q && pkt.emit),
    .in_ready_o   (emit_ready),
    .pkt_i        (pkt),
    .out_valid_o  (hdr_o.valid),
    .out_ready_i  (hdr_o.ready),
    .out_word_o   (hdr_o.header_word),
    .out_last_o   (hdr_o.is_last),
    .out_status_o (hdr_o.status)
  );

endmodule

`default_nettype wire

/* sv/arhp_build.sv */
// Header builder: checks one registered request and forms all of its quadlets.
`default_nettype none

module arhp_build (
  input  arhp_pkg::req_t req_i,
  input  arhp_pkg::cfg_t cfg_i,
  output arhp_pkg::pkt_t pkt_o
);
  import arhp_pkg::*;

  logic        known;
  logic        is_phy;
  logic        len_ok;
  logic        len_range;
  logic [3:0]  tcode;
  logic [2:0]  spd;
  logic [31:0] q0;
  logic [31:0] q1;
  logic [31:0] q3;
  status_e     st;

  // Block-length range shared by read block, write block and lock
  assign len_range = (req_i.data_length != 32'd0) && (req_i.data_length[31:16] == 16'd0);
  assign spd = req_i.use_default_speed ? cfg_i.default_speed : req_i.speed_code;

  // Decode tcode and length rule per request kind
  always_comb begin
    known  = 1'b1;
    is_phy = 1'b0;
    tcode  = TC_LOCK;
    len_ok = len_range;
    case (req_i.req_type)
      RT_READ_QUAD: begin
        tcode  = TC_READ_QUAD;
        len_ok = (req_i.data_length == 32'd0) || (req_i.data_length == 32'd4);
      end
      RT_READ_BLOCK: tcode = TC_READ_BLOCK;
      RT_WRITE_QUAD: begin
        tcode  = TC_WRITE_QUAD;
        len_ok = (req_i.data_length == 32'd4);
      end
      RT_WRITE_BLK: tcode = TC_WRITE_BLOCK;
      RT_LOCK:      tcode = TC_LOCK;
      RT_PHY:       is_phy = 1'b1;
      default:      known = 1'b0;
    endcase
  end

  // Pick the first failing check
  always_comb begin
    if (!len_ok) begin
      st = ST_BAD_LEN;
    end else if ((req_i.req_type == RT_LOCK) && (req_i.data_length[1:0] != 2'b00)) begin
      st = ST_UNALIGNED;
    end else if (req_i.addr_high[31:16] != 16'd0) begin
      st = ST_ADDR_HIGH;
    end else if (cfg_i.local_node_id == 16'd0) begin
      st = ST_NO_NODE;
    end else begin
      st = ST_OK;
    end
  end

  // Form the header quadlets
  assign q0 = {13'd0, spd, req_i.tlabel, RETRY_CODE, tcode, 4'd0};
  assign q1 = {cfg_i.local_node_id[15:6], req_i.dest_node, req_i.addr_high[15:0]};

  always_comb begin
    case (req_i.req_type)
      RT_WRITE_QUAD: q3 = cfg_i.swap_payload ? bswap32(req_i.payload) : req_i.payload;
      RT_LOCK:       q3 = {req_i.data_length[15:0], req_i.ext_tcode};
      default:       q3 = {req_i.data_length[15:0], 16'd0};
    endcase
  end

  // Assemble the packet
  always_comb begin
    pkt_o          = '0;
    pkt_o.emit     = known;
    pkt_o.status   = ST_OK;
    if (is_phy) begin
      pkt_o.words[0] = PHY_QUADLET0;
      pkt_o.words[1] = bswap32(req_i.phy_word1);
      pkt_o.words[2] = bswap32(req_i.phy_word2);
      pkt_o.last_idx = 2'd2;
    end else if (st != ST_OK) begin
      pkt_o.status   = st;
      pkt_o.last_idx = 2'd0;
    end else begin
      pkt_o.words[0] = q0;
      pkt_o.words[1] = q1;
      pkt_o.words[2] = req_i.addr_low;
      pkt_o.words[3] = q3;
      pkt_o.last_idx = (req_i.req_type == RT_READ_QUAD) ? 2'd2 : 2'd3;
    end
  end

endmodule

`default_nettype wire

/* sv/arhp_emit.sv */
// Result buffer: holds one built packet and sends its words one per cycle while the output is ready.
`default_nettype none

module arhp_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  arhp_pkg::pkt_t pkt_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    out_word_o,
  output logic           out_last_o,
  output logic [2:0]     out_status_o
);
  import arhp_pkg::*;

  logic                         valid_q, valid_d;
  logic [MAX_WORDS-1:0][31:0]   words_q;
  logic [$clog2(MAX_WORDS)-1:0] idx_q, idx_d;
  logic [$clog2(MAX_WORDS)-1:0] last_q;
  status_e                      st_q;
  logic                         fire;
  logic                         load;

  assign fire        = valid_q && out_ready_i;
  assign in_ready_o  = !valid_q || (out_ready_i && out_last_o);
  assign load        = in_valid_i && in_ready_o;

  assign out_valid_o  = valid_q;
  assign out_word_o   = words_q[idx_q];
  assign out_last_o   = (idx_q == last_q);
  assign out_status_o = st_q;

  // Advance the word index, reload on a new packet
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (fire) begin
      if (out_last_o) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Hold packet payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      words_q <= pkt_i.words;
      last_q  <= pkt_i.last_idx;
      st_q    <= pkt_i.status;
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q <= last_q))
    else $error("word index past last word");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (st_q != ST_OK)) |-> (out_last_o && (out_word_o == 32'd0)))
    else $error("error status not on a single zero word");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> (valid_q && $stable(idx_q)))
    else $error("word index moved under stall");

  a_mid_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !out_last_o) |=> (valid_q && (idx_q == $past(idx_q) + 1'b1)))
    else $error("packet dropped before its last word");

endmodule

`default_nettype wire
